// File: design/hsv_nearest_palette_match_defines.svh
// Assertion macros for the HSV nearest palette matcher.
// Used by the top level only; needs clk and rst_n in scope where expanded.
`ifndef HSV_NEAREST_PALETTE_MATCH_DEFINES_SVH
`define HSV_NEAREST_PALETTE_MATCH_DEFINES_SVH
`ifndef SYNTHESIS
`define HNPM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hnpm assertion failed");
`define HNPM_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) \
    else $error("hnpm assertion failed");
`else
`define HNPM_ASSERT(label, prop)
`define HNPM_ASSERT_NEXT(label, pre, post)
`endif
`endif

// File: design/hnpm_pkg.sv
// Shared constants, codes and types for the HSV nearest palette matcher.
// No dependencies.
package hnpm_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W = $clog2(PALETTE_DEPTH);
  localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

  localparam int FX_W  = 26;
  localparam int SQ_W  = 2 * FX_W;
  localparam int SUM_W = SQ_W + 2;

  localparam int HUE_SECTOR = 960;
  localparam int FX_SCALE   = 244800;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_APPEND  = 2'd1;
  localparam logic [1:0] OP_SET_DIS = 2'd2;
  localparam logic [1:0] OP_QUERY   = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       dflag;
    logic [2:0] sector;
    logic [9:0] wgt;
    logic [7:0] sat;
    logic [7:0] val;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] count;
  } result_t;

endpackage

// File: design/hsv_nearest_palette_match.sv
// Top level of the HSV nearest palette matcher: front end, queue, back end.
// Depends on hnpm_pkg, hnpm_front, hnpm_back and the defines header.
//
// Clear and set-disable commands are served straight from the idle state. Append
// and query commands first pass the target colour set-up states PREP1 to PREP3,
// then the back end reads one palette entry per cycle from its single memory
// read port for each used entry and waits for the scan pipeline to empty. A
// two-entry queue lets start be taken while the back end works; busy is high
// while the queue is full. Each result appears for one cycle with out_valid and
// must be captured then: the block cannot be stalled.
`include "hsv_nearest_palette_match_defines.svh"
module hsv_nearest_palette_match (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_entry_index,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic        in_disable_flag,
  input  logic [12:0] in_hue,
  input  logic [7:0]  in_saturation,
  input  logic [7:0]  in_brightness,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [7:0]  out_result_index,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic [8:0]  out_entry_count
);

  logic              q_valid, q_pop;
  hnpm_pkg::cmd_t    q_cmd;
  hnpm_pkg::result_t res;

  hnpm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_entry_index  (in_entry_index),
    .in_red_in       (in_red_in),
    .in_green_in     (in_green_in),
    .in_blue_in      (in_blue_in),
    .in_disable_flag (in_disable_flag),
    .in_hue          (in_hue),
    .in_saturation   (in_saturation),
    .in_brightness   (in_brightness),
    .q_pop           (q_pop),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd)
  );

  hnpm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign out_status       = res.status;
  assign out_result_index = res.index;
  assign out_red_out      = res.red;
  assign out_green_out    = res.green;
  assign out_blue_out     = res.blue;
  assign out_entry_count  = res.count;

  `HNPM_ASSERT(a_none_zero, out_valid && out_status == hnpm_pkg::ST_NONE |-> out_result_index == 8'd0 && out_red_out == 8'd0 && out_green_out == 8'd0 && out_blue_out == 8'd0)
  `HNPM_ASSERT(a_full_count, out_valid && out_status == hnpm_pkg::ST_FULL |-> out_entry_count == 9'(hnpm_pkg::PALETTE_DEPTH))
  `HNPM_ASSERT(a_dup_index, out_valid && out_status == hnpm_pkg::ST_DUP |-> 9'(out_result_index) < out_entry_count)
  `HNPM_ASSERT_NEXT(a_busy_rise, !busy && !start, !busy)

endmodule

// File: design/hnpm_front.sv
// Front end: takes commands, folds the hue into sector and weight, queues them.
// Depends on hnpm_pkg.
module hnpm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic [7:0]         in_entry_index,
  input  logic [7:0]         in_red_in,
  input  logic [7:0]         in_green_in,
  input  logic [7:0]         in_blue_in,
  input  logic               in_disable_flag,
  input  logic [12:0]        in_hue,
  input  logic [7:0]         in_saturation,
  input  logic [7:0]         in_brightness,
  input  logic               q_pop,
  output logic               q_valid,
  output hnpm_pkg::cmd_t     q_cmd
);

  hnpm_pkg::cmd_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push, pop;
  logic [12:0]    h_red;
  logic [10:0]    rem;
  logic [9:0]     fx;
  hnpm_pkg::cmd_t cmd;

  always_comb begin
    h_red = (in_hue >= 13'd5760) ? in_hue - 13'd5760 : in_hue;
    if (h_red >= 13'd3840) begin
      rem = 11'(h_red - 13'd3840);
    end else if (h_red >= 13'd1920) begin
      rem = 11'(h_red - 13'd1920);
    end else begin
      rem = 11'(h_red);
    end
    fx = (rem >= 11'd960) ? 10'(rem - 11'd960) : 10'(11'd960 - rem);
    cmd.op     = in_opcode;
    cmd.idx    = in_entry_index;
    cmd.red    = in_red_in;
    cmd.green  = in_green_in;
    cmd.blue   = in_blue_in;
    cmd.dflag  = in_disable_flag;
    cmd.wgt    = 10'd960 - fx;
    cmd.sat    = in_saturation;
    cmd.val    = in_brightness;
    if (h_red >= 13'd4800) begin
      cmd.sector = 3'd5;
    end else if (h_red >= 13'd3840) begin
      cmd.sector = 3'd4;
    end else if (h_red >= 13'd2880) begin
      cmd.sector = 3'd3;
    end else if (h_red >= 13'd1920) begin
      cmd.sector = 3'd2;
    end else if (h_red >= 13'd960) begin
      cmd.sector = 3'd1;
    end else begin
      cmd.sector = 3'd0;
    end
  end

  assign busy    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = q_r[rd_ptr_r];
  assign push    = start && !busy;
  assign pop     = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = 2'(cnt_r + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: design/hnpm_back.sv
// Back end: palette memories, target colour set-up, scan pipeline and results.
// Depends on hnpm_pkg.
module hnpm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  hnpm_pkg::cmd_t     q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  output hnpm_pkg::result_t  out_res
);

  localparam int IW = hnpm_pkg::IDX_W;
  localparam int CW = hnpm_pkg::CNT_W;
  localparam int FW = hnpm_pkg::FX_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP1 = 3'd1;
  localparam logic [2:0] S_PREP2 = 3'd2;
  localparam logic [2:0] S_PREP3 = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;

  logic [2:0]         state_r, state_nxt;
  hnpm_pkg::cmd_t     cur_r, cur_nxt;
  logic [CW-1:0]      used_r, used_nxt;
  logic [CW-1:0]      scan_r, scan_nxt;
  logic [15:0]        vs_r, vs_nxt, vns_r, vns_nxt;
  logic [FW-1:0]      c_r, c_nxt, x_r, x_nxt, m_r, m_nxt;
  logic [FW-1:0]      tr_r, tr_nxt, tg_r, tg_nxt, tb_r, tb_nxt;
  logic               out_valid_r, out_valid_nxt;
  hnpm_pkg::result_t  res_r, res_nxt;

  logic [23:0]        rgb_mem [hnpm_pkg::PALETTE_DEPTH];
  logic               off_mem [hnpm_pkg::PALETTE_DEPTH];
  logic               wr_rgb_en, wr_off_en, wr_off;
  logic [IW-1:0]      wr_addr, rd_addr;
  logic [23:0]        wr_rgb;
  logic               rd_en;

  logic               s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic [IW-1:0]      s1_idx_r, s2_idx_r, s3_idx_r, s4_idx_r;
  logic [23:0]        rd_rgb_r, s2_rgb_r, s3_rgb_r, s4_rgb_r;
  logic               rd_off_r, s2_off_r, s3_off_r, s4_off_r;
  logic               s2_eq_r, s3_eq_r, s4_eq_r;
  logic [FW-1:0]      dr_r, dg_r, db_r;
  logic [hnpm_pkg::SQ_W-1:0]  qr_r, qg_r, qb_r;
  logic [hnpm_pkg::SUM_W-1:0] sum_r;

  logic               found_r, found_nxt;
  logic [hnpm_pkg::SUM_W-1:0] best_d_r, best_d_nxt;
  logic [IW-1:0]      best_idx_r, best_idx_nxt;
  logic [23:0]        best_rgb_r, best_rgb_nxt;
  logic               take;

  function automatic logic [FW-1:0] abs_diff(input logic [7:0] p, input logic [FW-1:0] t);
    logic [FW-1:0] pk;
    pk = FW'(p * hnpm_pkg::FX_SCALE);
    abs_diff = (pk >= t) ? pk - t : t - pk;
  endfunction

  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign rd_addr   = scan_r[IW-1:0];

  always_comb begin
    if (cur_r.op == hnpm_pkg::OP_QUERY) begin
      take = s4_v_r && !s4_off_r && (!found_r || sum_r < best_d_r);
    end else begin
      take = s4_v_r && s4_eq_r && !found_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    used_nxt      = used_r;
    scan_nxt      = scan_r;
    vs_nxt        = vs_r;
    vns_nxt       = vns_r;
    c_nxt         = c_r;
    x_nxt         = x_r;
    m_nxt         = m_r;
    tr_nxt        = tr_r;
    tg_nxt        = tg_r;
    tb_nxt        = tb_r;
    out_valid_nxt = 1'b0;
    res_nxt       = res_r;
    q_pop         = 1'b0;
    wr_rgb_en     = 1'b0;
    wr_off_en     = 1'b0;
    wr_off        = 1'b0;
    wr_addr       = '0;
    wr_rgb        = {cur_r.red, cur_r.green, cur_r.blue};
    rd_en         = 1'b0;
    found_nxt     = found_r;
    best_d_nxt    = best_d_r;
    best_idx_nxt  = best_idx_r;
    best_rgb_nxt  = best_rgb_r;

    if (take) begin
      found_nxt    = 1'b1;
      best_d_nxt   = sum_r;
      best_idx_nxt = s4_idx_r;
      best_rgb_nxt = s4_rgb_r;
    end

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_cmd;
          case (q_cmd.op)
            hnpm_pkg::OP_CLEAR: begin
              used_nxt      = '0;
              out_valid_nxt = 1'b1;
              res_nxt       = '0;
            end
            hnpm_pkg::OP_SET_DIS: begin
              if (16'(q_cmd.idx) < 16'(used_r)) begin
                wr_off_en = 1'b1;
                wr_off    = q_cmd.dflag;
                wr_addr   = IW'(q_cmd.idx);
              end
              out_valid_nxt = 1'b1;
              res_nxt       = '0;
              res_nxt.index = q_cmd.idx;
              res_nxt.count = 9'(used_r);
            end
            default: begin
              state_nxt = S_PREP1;
            end
          endcase
        end
      end
      S_PREP1: begin
        vs_nxt  = 16'(cur_r.val) * 16'(cur_r.sat);
        vns_nxt = 16'(cur_r.val) * 16'(8'd255 - cur_r.sat);
        state_nxt = S_PREP2;
      end
      S_PREP2: begin
        c_nxt = FW'(vs_r * hnpm_pkg::HUE_SECTOR);
        x_nxt = FW'(vs_r) * FW'(cur_r.wgt);
        m_nxt = FW'(vns_r * hnpm_pkg::HUE_SECTOR);
        state_nxt = S_PREP3;
      end
      S_PREP3: begin
        case (cur_r.sector)
          3'd0: begin tr_nxt = c_r; tg_nxt = x_r; tb_nxt = '0;  end
          3'd1: begin tr_nxt = x_r; tg_nxt = c_r; tb_nxt = '0;  end
          3'd2: begin tr_nxt = '0;  tg_nxt = c_r; tb_nxt = x_r; end
          3'd3: begin tr_nxt = '0;  tg_nxt = x_r; tb_nxt = c_r; end
          3'd4: begin tr_nxt = x_r; tg_nxt = '0;  tb_nxt = c_r; end
          default: begin tr_nxt = c_r; tg_nxt = '0; tb_nxt = x_r; end
        endcase
        tr_nxt    = tr_nxt + m_r;
        tg_nxt    = tg_nxt + m_r;
        tb_nxt    = tb_nxt + m_r;
        scan_nxt  = '0;
        found_nxt = 1'b0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_r < used_r) begin
          rd_en    = 1'b1;
          scan_nxt = scan_r + 1'b1;
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!(s1_v_r || s2_v_r || s3_v_r || s4_v_r)) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          res_nxt       = '0;
          res_nxt.count = 9'(used_r);
          if (cur_r.op == hnpm_pkg::OP_QUERY) begin
            if (found_r) begin
              res_nxt.index = 8'(best_idx_r);
              {res_nxt.red, res_nxt.green, res_nxt.blue} = best_rgb_r;
            end else begin
              res_nxt.status = hnpm_pkg::ST_NONE;
            end
          end else if (found_r) begin
            res_nxt.status = hnpm_pkg::ST_DUP;
            res_nxt.index  = 8'(best_idx_r);
            {res_nxt.red, res_nxt.green, res_nxt.blue} = best_rgb_r;
          end else if (used_r == CW'(hnpm_pkg::PALETTE_DEPTH)) begin
            res_nxt.status = hnpm_pkg::ST_FULL;
          end else begin
            wr_rgb_en     = 1'b1;
            wr_off_en     = 1'b1;
            wr_addr       = used_r[IW-1:0];
            used_nxt      = used_r + 1'b1;
            res_nxt.index = 8'(used_r);
            res_nxt.count = 9'(used_nxt);
            {res_nxt.red, res_nxt.green, res_nxt.blue} = wr_rgb;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_rgb_en) begin
      rgb_mem[wr_addr] <= wr_rgb;
    end
    if (wr_off_en) begin
      off_mem[wr_addr] <= wr_off;
    end
    rd_rgb_r <= rgb_mem[rd_addr];
    rd_off_r <= off_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= rd_addr;
    s2_idx_r <= s1_idx_r;
    s2_rgb_r <= rd_rgb_r;
    s2_off_r <= rd_off_r;
    s2_eq_r  <= (rd_rgb_r == {cur_r.red, cur_r.green, cur_r.blue});
    dr_r     <= abs_diff(rd_rgb_r[23:16], tr_r);
    dg_r     <= abs_diff(rd_rgb_r[15:8], tg_r);
    db_r     <= abs_diff(rd_rgb_r[7:0], tb_r);
    s3_idx_r <= s2_idx_r;
    s3_rgb_r <= s2_rgb_r;
    s3_off_r <= s2_off_r;
    s3_eq_r  <= s2_eq_r;
    qr_r     <= dr_r * dr_r;
    qg_r     <= dg_r * dg_r;
    qb_r     <= db_r * db_r;
    s4_idx_r <= s3_idx_r;
    s4_rgb_r <= s3_rgb_r;
    s4_off_r <= s3_off_r;
    s4_eq_r  <= s3_eq_r;
    sum_r    <= hnpm_pkg::SUM_W'(qr_r) + hnpm_pkg::SUM_W'(qg_r) + hnpm_pkg::SUM_W'(qb_r);
    cur_r    <= cur_nxt;
    scan_r   <= scan_nxt;
    vs_r     <= vs_nxt;
    vns_r    <= vns_nxt;
    c_r      <= c_nxt;
    x_r      <= x_nxt;
    m_r      <= m_nxt;
    tr_r     <= tr_nxt;
    tg_r     <= tg_nxt;
    tb_r     <= tb_nxt;
    res_r    <= res_nxt;
    best_d_r   <= best_d_nxt;
    best_idx_r <= best_idx_nxt;
    best_rgb_r <= best_rgb_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      s1_v_r      <= rd_en;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      found_r     <= found_nxt;
    end
  end

endmodule

// File: bench/hnpm_checker.sv
// Checker for the HSV nearest palette matcher: watches both channels, predicts results.
// Depends on hnpm_pkg; instantiated beside the block by tb_hsv_nearest_palette_match.
module hnpm_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_entry_index,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic        in_disable_flag,
  input  logic [12:0] in_hue,
  input  logic [7:0]  in_saturation,
  input  logic [7:0]  in_brightness,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [7:0]  out_result_index,
  input  logic [7:0]  out_red_out,
  input  logic [7:0]  out_green_out,
  input  logic [7:0]  out_blue_out,
  input  logic [8:0]  out_entry_count,
  output int          fail_count,
  output int          pending,
  output int          query_count,
  output int          append_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import hnpm_pkg::*;

  logic [7:0] pal_r [PALETTE_DEPTH];
  logic [7:0] pal_g [PALETTE_DEPTH];
  logic [7:0] pal_b [PALETTE_DEPTH];
  logic       pal_off [PALETTE_DEPTH];
  int         used;
  result_t    expected_q[$];

  function automatic logic [63:0] sqdist(logic [7:0] p, longint t);
    longint d;
    d = longint'(p) * FX_SCALE - t;
    if (d < 0) d = -d;
    return d * d;
  endfunction

  task automatic predict_match();
    result_t r;
    int h, sec, fx, hit;
    longint s, v, c, x, m, tr, tg, tb;
    logic [63:0] d, bestd;
    r = '0;
    case (in_opcode)
      OP_CLEAR: used = 0;
      OP_APPEND: begin
        append_count++;
        hit = -1;
        for (int i = 0; i < used; i++)
          if (hit < 0 && pal_r[i] == in_red_in && pal_g[i] == in_green_in &&
              pal_b[i] == in_blue_in) hit = i;
        if (hit >= 0) begin
          r.status = ST_DUP; r.index = hit;
          r.red = in_red_in; r.green = in_green_in; r.blue = in_blue_in;
        end else if (used >= PALETTE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pal_r[used] = in_red_in; pal_g[used] = in_green_in;
          pal_b[used] = in_blue_in; pal_off[used] = 1'b0;
          r.status = ST_OK; r.index = used;
          r.red = in_red_in; r.green = in_green_in; r.blue = in_blue_in;
          used++;
        end
      end
      OP_SET_DIS: begin
        if (in_entry_index < used) pal_off[in_entry_index] = in_disable_flag;
        r.status = ST_OK; r.index = in_entry_index;
      end
      default: begin
        query_count++;
        h = in_hue;
        if (h >= 5760) h -= 5760;
        sec = h / HUE_SECTOR;
        fx = (h % (2 * HUE_SECTOR)) - HUE_SECTOR;
        if (fx < 0) fx = -fx;
        s = in_saturation; v = in_brightness;
        c = v * s * HUE_SECTOR;
        x = v * s * (HUE_SECTOR - fx);
        m = v * (255 - s) * HUE_SECTOR;
        case (sec)
          0: begin tr = c; tg = x; tb = 0; end
          1: begin tr = x; tg = c; tb = 0; end
          2: begin tr = 0; tg = c; tb = x; end
          3: begin tr = 0; tg = x; tb = c; end
          4: begin tr = x; tg = 0; tb = c; end
          default: begin tr = c; tg = 0; tb = x; end
        endcase
        tr += m; tg += m; tb += m;
        hit = -1; bestd = '0;
        for (int i = 0; i < used; i++) begin
          if (!pal_off[i]) begin
            d = sqdist(pal_r[i], tr) + sqdist(pal_g[i], tg) + sqdist(pal_b[i], tb);
            if (hit < 0 || d < bestd) begin
              hit = i; bestd = d;
            end
          end
        end
        if (hit < 0) r.status = ST_NONE;
        else begin
          r.status = ST_OK; r.index = hit;
          r.red = pal_r[hit]; r.green = pal_g[hit]; r.blue = pal_b[hit];
        end
      end
    endcase
    r.count = used;
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic compare_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0; used = 0; query_count = 0; append_count = 0; pending = 0;
  end

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $error("result with no transaction outstanding");
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        compare_field("status", e.status, out_status);
        compare_field("result_index", e.index, out_result_index);
        compare_field("red_out", e.red, out_red_out);
        compare_field("green_out", e.green, out_green_out);
        compare_field("blue_out", e.blue, out_blue_out);
        compare_field("entry_count", e.count, out_entry_count);
      end
    end
    if (rst_n && start && !busy) predict_match();
    pending = expected_q.size();
  end
endmodule

// File: bench/tb_hsv_nearest_palette_match.sv
// Testbench top for the HSV nearest palette matcher: stimulus, reset and verdict.
// Depends on hnpm_pkg, hsv_nearest_palette_match and hnpm_checker.
module tb_hsv_nearest_palette_match;
  timeunit 1ns;
  timeprecision 1ps;
  import hnpm_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_opcode = OP_CLEAR;
  logic [7:0]  in_entry_index = '0;
  logic [7:0]  in_red_in = '0;
  logic [7:0]  in_green_in = '0;
  logic [7:0]  in_blue_in = '0;
  logic        in_disable_flag = 1'b0;
  logic [12:0] in_hue = '0;
  logic [7:0]  in_saturation = '0;
  logic [7:0]  in_brightness = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [7:0]  out_result_index, out_red_out, out_green_out, out_blue_out;
  logic [8:0]  out_entry_count;
  int          fail_count, pending, query_count, append_count;
  int          sent;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  hsv_nearest_palette_match u_dut (.*);

  hnpm_checker u_chk (.*);

  task automatic send_txn(logic [1:0] op, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                          logic [7:0] b, logic df, logic [12:0] h, logic [7:0] s,
                          logic [7:0] v, bit gaps);
    int gap;
    if (gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_opcode <= op; in_entry_index <= idx;
    in_red_in <= r; in_green_in <= g; in_blue_in <= b;
    in_disable_flag <= df; in_hue <= h; in_saturation <= s; in_brightness <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic random_txn(bit gaps, int pool);
    int k;
    logic [1:0] op;
    k = $urandom_range(0, 99);
    if (k < 2) op = OP_CLEAR;
    else if (k < 40) op = OP_APPEND;
    else if (k < 52) op = OP_SET_DIS;
    else op = OP_QUERY;
    send_txn(op, (k & 1) ? $urandom_range(0, 255) : $urandom_range(0, 40),
             pool ? $urandom_range(0, pool) * 63 : $urandom_range(0, 255),
             pool ? $urandom_range(0, pool) * 85 : $urandom_range(0, 255),
             $urandom_range(0, 255), $urandom_range(0, 1),
             ($urandom_range(0, 9) == 0) ? $urandom_range(5760, 8191) : $urandom_range(0, 5759),
             $urandom_range(0, 255), $urandom_range(0, 255), gaps);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_txn(OP_QUERY, 0, 0, 0, 0, 0, 0, 255, 255, 1);
    send_txn(OP_APPEND, 0, 255, 0, 0, 0, 0, 0, 0, 1);
    send_txn(OP_APPEND, 0, 0, 255, 0, 0, 0, 0, 0, 0);
    send_txn(OP_APPEND, 0, 0, 0, 255, 0, 0, 0, 0, 1);
    send_txn(OP_APPEND, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_txn(OP_APPEND, 0, 255, 255, 255, 0, 0, 0, 0, 1);
    send_txn(OP_APPEND, 0, 255, 0, 0, 0, 0, 0, 0, 0);
    send_txn(OP_QUERY, 0, 0, 0, 0, 0, 0, 255, 255, 0);
    send_txn(OP_QUERY, 0, 0, 0, 0, 0, 1920, 255, 255, 1);
    send_txn(OP_QUERY, 0, 0, 0, 0, 0, 8191, 255, 255, 0);
    send_txn(OP_QUERY, 0, 0, 0, 0, 0, 5760, 0, 0, 1);
    send_txn(OP_QUERY, 0, 0, 0, 0, 0, 5759, 128, 200, 0);
    send_txn(OP_SET_DIS, 0, 0, 0, 0, 1, 0, 0, 0, 1);
    send_txn(OP_QUERY, 0, 0, 0, 0, 0, 0, 255, 255, 0);
    send_txn(OP_SET_DIS, 255, 0, 0, 0, 1, 0, 0, 0, 0);
    for (int i = 1; i < 5; i++) send_txn(OP_SET_DIS, i, 0, 0, 0, 1, 0, 0, 0, 1);
    send_txn(OP_QUERY, 0, 0, 0, 0, 0, 960, 10, 10, 0);
    send_txn(OP_SET_DIS, 3, 0, 0, 0, 0, 0, 0, 0, 1);
    send_txn(OP_QUERY, 0, 0, 0, 0, 0, 3000, 100, 100, 0);
    send_txn(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    send_txn(OP_QUERY, 0, 0, 0, 0, 0, 4000, 50, 50, 0);
    // fill the table to full, then exercise the full status
    for (int i = 0; i < 258; i++)
      send_txn(OP_APPEND, 0, i[7:0], i[8] ? 8'd1 : 8'd7, 8'd200, 0, 0, 0, 0, 1);
    for (int i = 0; i < 60; i++) random_txn(1, 0);
    send_txn(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 700; i++) random_txn(1, (i % 200 < 100) ? 4 : 0);
    for (int i = 0; i < 300; i++) random_txn(0, (i % 150 < 60) ? 3 : 0);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d transactions: %0d appends, %0d queries, table filled past full.",
             sent, append_count, query_count);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
